// File: rtl/core/ifbi_pkg.sv
// Shared constants, register indexes and helper functions of the frame integrator.
package ifbi_pkg;

   localparam int WARMUP_DEFAULT = 6;
   localparam int COMP_W         = 21;
   localparam int RATE_W         = 24;
   localparam int VEC_W          = 63;
   localparam int DT_W           = 24;
   localparam int HIST_DEPTH     = 6;
   localparam int NUM_COMP       = 9;
   localparam int CSR_IDX_W      = 8;
   localparam int CSR_DATA_W     = 64;

   localparam logic [CSR_IDX_W-1:0] REG_INIT_X    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_Y    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_Z    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 8'd3;

   localparam logic [VEC_W-1:0] INIT_X_RESET  = 63'd131072;
   localparam logic [VEC_W-1:0] INIT_Y_RESET  = 63'd274877906944;
   localparam logic [VEC_W-1:0] INIT_Z_RESET  = 63'd576460752303423488;
   localparam logic [DT_W-1:0]  DT_RESET      = 24'd167772;

   // floor(x/147) for 0 <= x < 2^29 as (x*RECIP_M)>>37 plus one correction
   localparam logic signed [30:0] RECIP_M     = 31'sd934958867;
   localparam logic signed [30:0] DIV_D       = 31'sd147;
   localparam logic signed [67:0] ROUND_OFS   = 68'sd19730006016;  // 147 * 2^27
   localparam logic signed [40:0] SAT_SPAN    = 41'sd154140672;    // 147 * 2^20
   localparam logic signed [COMP_W-1:0] COMP_MAX = 21'sd1048575;
   localparam logic signed [COMP_W-1:0] COMP_MIN = -21'sd1048576;

   // BDF6 history weights, scaled by 147 (360,-450,400,-225,72,-10)
   function automatic logic signed [30:0] hist_coef(input logic [2:0] age);
      logic signed [30:0] c;
      unique case (age)
         3'd0:    c = 31'sd360;
         3'd1:    c = -31'sd450;
         3'd2:    c = 31'sd400;
         3'd3:    c = -31'sd225;
         3'd4:    c = 31'sd72;
         3'd5:    c = -31'sd10;
         default: c = 31'sd0;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] add_mod3(input logic [1:0] v, input logic [1:0] n);
      logic [2:0] s;
      s = {1'b0, v} + {1'b0, n};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

endpackage

// File: rtl/core/ifbi_channels.sv
// Handshake channels of the frame integrator: gyro items, frame items, register writes.
interface ifbi_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ifbi_pkg::RATE_W-1:0]     rate_x;
   logic signed [ifbi_pkg::RATE_W-1:0]     rate_y;
   logic signed [ifbi_pkg::RATE_W-1:0]     rate_z;
   modport source (output valid, rate_x, rate_y, rate_z, input ready);
   modport sink   (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

interface ifbi_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ifbi_pkg::COMP_W-1:0]     xvec_x;
   logic signed [ifbi_pkg::COMP_W-1:0]     xvec_y;
   logic signed [ifbi_pkg::COMP_W-1:0]     xvec_z;
   logic signed [ifbi_pkg::COMP_W-1:0]     yvec_x;
   logic signed [ifbi_pkg::COMP_W-1:0]     yvec_y;
   logic signed [ifbi_pkg::COMP_W-1:0]     yvec_z;
   logic signed [ifbi_pkg::COMP_W-1:0]     zvec_x;
   logic signed [ifbi_pkg::COMP_W-1:0]     zvec_y;
   logic signed [ifbi_pkg::COMP_W-1:0]     zvec_z;
   modport source (output valid, xvec_x, xvec_y, xvec_z, yvec_x, yvec_y, yvec_z,
                   zvec_x, zvec_y, zvec_z, input ready);
   modport sink   (input valid, xvec_x, xvec_y, xvec_z, yvec_x, yvec_y, yvec_z,
                   zvec_x, zvec_y, zvec_z, output ready);
endinterface

interface ifbi_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [ifbi_pkg::CSR_IDX_W-1:0]         index;
   logic [ifbi_pkg::CSR_DATA_W-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/imu_frame_bdf6_integrator_unit.sv
// Top level: IMU orientation-frame integrator with a BDF6 step on one shared multiplier.
//
// req_ch takes one gyro item (rate_x/y/z, Q8.16). rsp_ch returns one item per
// request: the nine frame components in Q4.17. csr_ch writes the initial frame
// vectors (index 0..2) and the time step (index 3); it is always ready and
// should be used only while no item is in flight. Unknown indexes are dropped.
// The first WARMUP_SAMPLES items return the configured initial frame, one
// component per cycle; rsp_ch.valid can rise only once all nine are stored.
// Later items run each component through the single 35x31 multiplier (cross
// product, six history weights, time step, reciprocal divide by 147 and its
// check) before rsp_ch.valid rises. req_ch.ready is high only when the
// sequencer is idle, so no new item is taken while one is being computed.
// The result sits in an output register; the next item may be accepted while
// it waits, but that item's result is held until rsp_ch takes the previous one.
// Synchronous reset clears the sequencer, warm-up count and registers to
// their reset values; frame history is not cleared, warm-up fills it.
module imu_frame_bdf6_integrator_unit #(
   parameter int WARMUP_SAMPLES = ifbi_pkg::WARMUP_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ifbi_req_if.sink    req_ch,
   ifbi_rsp_if.source  rsp_ch,
   ifbi_csr_if.sink    csr_ch
);

   localparam int WCNT_W   = $clog2(WARMUP_SAMPLES + 1);
   localparam int MEM_SIZE = ifbi_pkg::NUM_COMP * ifbi_pkg::HIST_DEPTH;
   localparam int ADDR_W   = $clog2(MEM_SIZE);

   typedef enum logic [1:0] {ST_IDLE, ST_WARM, ST_CALC, ST_DONE} state_type;

   state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  vec_ff, vec_in, cmp_ff, cmp_in;
   logic [2:0]  wptr_ff, wptr_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [ifbi_pkg::VEC_W-1:0] init_ff [3];
   logic [ifbi_pkg::VEC_W-1:0] init_in [3];
   logic [ifbi_pkg::DT_W-1:0]  dt_ff, dt_in;

   logic signed [ifbi_pkg::RATE_W-1:0] rate_ff [3];
   logic signed [ifbi_pkg::RATE_W-1:0] rate_in [3];
   logic signed [ifbi_pkg::RATE_W-1:0] new_rate_ff [3];
   logic signed [ifbi_pkg::RATE_W-1:0] new_rate_in [3];

   logic signed [ifbi_pkg::COMP_W-1:0] res_ff [ifbi_pkg::NUM_COMP];
   logic signed [ifbi_pkg::COMP_W-1:0] res_in [ifbi_pkg::NUM_COMP];
   logic signed [ifbi_pkg::COMP_W-1:0] out_ff [ifbi_pkg::NUM_COMP];
   logic signed [ifbi_pkg::COMP_W-1:0] out_in [ifbi_pkg::NUM_COMP];

   logic signed [65:0] prod_ff, prod_in;
   logic signed [45:0] cr_ff, cr_in;
   logic signed [33:0] hs_ff, hs_in;
   logic [28:0] u_ff, u_in;
   logic        sat_hi_ff, sat_hi_in, sat_lo_ff, sat_lo_in;
   logic [21:0] q0_ff, q0_in;

   // history memory
   logic [ifbi_pkg::COMP_W-1:0] hist_mem [MEM_SIZE];
   logic signed [ifbi_pkg::COMP_W-1:0] rd_ff;
   logic [ADDR_W-1:0] raddr, waddr;
   logic        wr_en;
   logic signed [ifbi_pkg::COMP_W-1:0] wr_data;

   logic [3:0]  comp_idx, rd_comp;
   logic [1:0]  rd_cmp;
   logic [2:0]  rd_age, rd_slot, wr_slot;
   logic signed [34:0] mul_a;
   logic signed [30:0] mul_b;
   logic signed [46:0] cr_rnd;
   logic signed [33:0] c21;
   logic signed [67:0] prod_ext, x60, xr;
   logic signed [39:0] t28;
   logic signed [40:0] s_sum, u_wide;
   logic [30:0] rem;
   logic [21:0] q_fix;
   logic signed [ifbi_pkg::COMP_W-1:0] calc_val, warm_val;
   logic [ifbi_pkg::VEC_W-1:0] warm_vec;
   logic        last_comp, req_fire, rsp_fire;

   function automatic logic [3:0] comp_of(input logic [1:0] v, input logic [1:0] k);
      return 4'({v, 1'b0}) + 4'(v) + 4'(k);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] c, input logic [2:0] s);
      logic [6:0] a;
      a = {1'b0, c, 2'b00} + {2'b00, c, 1'b0} + {4'b0, s};
      return a[ADDR_W-1:0];
   endfunction

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ch.ready;
   assign comp_idx  = comp_of(vec_ff, cmp_ff);
   assign last_comp = (vec_ff == 2'd2) && (cmp_ff == 2'd2);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.xvec_x = out_ff[0];
   assign rsp_ch.xvec_y = out_ff[1];
   assign rsp_ch.xvec_z = out_ff[2];
   assign rsp_ch.yvec_x = out_ff[3];
   assign rsp_ch.yvec_y = out_ff[4];
   assign rsp_ch.yvec_z = out_ff[5];
   assign rsp_ch.zvec_x = out_ff[6];
   assign rsp_ch.zvec_y = out_ff[7];
   assign rsp_ch.zvec_z = out_ff[8];

   // read address: two neighbor components of the same vector, then own history
   always_comb begin
      rd_cmp = cmp_ff;
      rd_age = 3'd0;
      unique case (step_ff)
         4'd0:    rd_cmp = ifbi_pkg::add_mod3(cmp_ff, 2'd2);
         4'd1:    rd_cmp = ifbi_pkg::add_mod3(cmp_ff, 2'd1);
         4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: rd_age = 3'(step_ff - 4'd2);
         default: rd_age = 3'd0;
      endcase
      rd_comp = comp_of(vec_ff, rd_cmp);
      rd_slot = (wptr_ff >= rd_age) ? 3'(wptr_ff - rd_age) : 3'(wptr_ff + 3'd6 - rd_age);
      raddr   = addr_of(rd_comp, rd_slot);
      wr_slot = (wptr_ff == 3'd5) ? 3'd0 : 3'(wptr_ff + 3'd1);
      waddr   = addr_of(comp_idx, wr_slot);
   end

   // shared multiplier operand select
   always_comb begin
      cr_rnd = {cr_ff[45], cr_ff} + 47'sd2048;
      c21    = cr_rnd[45:12];
      mul_a  = '0;
      mul_b  = '0;
      unique case (step_ff)
         4'd1: begin
            mul_a = 35'(rd_ff);
            mul_b = 31'(rate_ff[ifbi_pkg::add_mod3(cmp_ff, 2'd1)]);
         end
         4'd2: begin
            mul_a = 35'(rd_ff);
            mul_b = 31'(rate_ff[ifbi_pkg::add_mod3(cmp_ff, 2'd2)]);
         end
         4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
            mul_a = 35'(rd_ff);
            mul_b = ifbi_pkg::hist_coef(3'(step_ff - 4'd3));
         end
         4'd9: begin
            mul_a = 35'(c21);
            mul_b = $signed({7'b0, dt_ff});
         end
         4'd11: begin
            mul_a = $signed({6'b0, u_ff});
            mul_b = ifbi_pkg::RECIP_M;
         end
         4'd12: begin
            // quotient estimate straight from the reciprocal product
            mul_a = $signed({13'b0, prod_ff[58:37]});
            mul_b = ifbi_pkg::DIV_D;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // rounding, saturation window, divide correction, warm-up value and history write
   always_comb begin
      prod_ext = {{2{prod_ff[65]}}, prod_ff};
      x60      = (prod_ext <<< 6) - (prod_ext <<< 2);
      xr       = x60 + ifbi_pkg::ROUND_OFS;
      t28      = xr[67:28];
      s_sum    = {{7{hs_ff[33]}}, hs_ff} + {t28[39], t28};
      u_wide   = s_sum + ifbi_pkg::SAT_SPAN;
      rem      = {2'b00, u_ff} - prod_ff[30:0];
      q_fix    = (rem >= 31'd147) ? 22'(q0_ff + 22'd1) : q0_ff;
      priority if (sat_hi_ff)
         calc_val = ifbi_pkg::COMP_MAX;
      else if (sat_lo_ff)
         calc_val = ifbi_pkg::COMP_MIN;
      else
         calc_val = $signed({~q_fix[20], q_fix[19:0]});
      warm_vec = init_ff[vec_ff];
      unique case (cmp_ff)
         2'd0:    warm_val = $signed(warm_vec[20:0]);
         2'd1:    warm_val = $signed(warm_vec[41:21]);
         default: warm_val = $signed(warm_vec[62:42]);
      endcase
      wr_en   = (state_ff == ST_WARM) || ((state_ff == ST_CALC) && (step_ff == 4'd13));
      wr_data = (state_ff == ST_WARM) ? warm_val : calc_val;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      vec_in       = vec_ff;
      cmp_in       = cmp_ff;
      wptr_in      = wptr_ff;
      wcnt_in      = wcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      init_in      = init_ff;
      dt_in        = dt_ff;
      rate_in      = rate_ff;
      new_rate_in  = new_rate_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      cr_in        = cr_ff;
      hs_in        = hs_ff;
      u_in         = u_ff;
      sat_hi_in    = sat_hi_ff;
      sat_lo_in    = sat_lo_ff;
      q0_in        = q0_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ifbi_pkg::REG_INIT_X:    init_in[0] = csr_ch.data[62:0];
            ifbi_pkg::REG_INIT_Y:    init_in[1] = csr_ch.data[62:0];
            ifbi_pkg::REG_INIT_Z:    init_in[2] = csr_ch.data[62:0];
            ifbi_pkg::REG_TIME_STEP: dt_in      = csr_ch.data[23:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               new_rate_in[0] = req_ch.rate_x;
               new_rate_in[1] = req_ch.rate_y;
               new_rate_in[2] = req_ch.rate_z;
               vec_in  = 2'd0;
               cmp_in  = 2'd0;
               step_in = 4'd0;
               if (wcnt_ff < WCNT_W'(WARMUP_SAMPLES)) begin
                  wcnt_in  = WCNT_W'(wcnt_ff + 1'b1);
                  state_in = ST_WARM;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_WARM: begin
            res_in[comp_idx] = warm_val;
            if (last_comp) state_in = ST_DONE;
            cmp_in = (cmp_ff == 2'd2) ? 2'd0 : 2'(cmp_ff + 2'd1);
            if (cmp_ff == 2'd2) vec_in = 2'(vec_ff + 2'd1);
         end
         ST_CALC: begin
            step_in = 4'(step_ff + 4'd1);
            unique case (step_ff)
               4'd2:  cr_in = prod_ff[45:0];
               4'd3:  cr_in = cr_ff - prod_ff[45:0];
               4'd4:  hs_in = prod_ff[33:0];
               4'd5, 4'd6, 4'd7, 4'd8, 4'd9: hs_in = hs_ff + prod_ff[33:0];
               4'd10: begin
                  sat_hi_in = (s_sum >= ifbi_pkg::SAT_SPAN);
                  sat_lo_in = (s_sum < -ifbi_pkg::SAT_SPAN);
                  u_in      = u_wide[28:0];
               end
               4'd12: q0_in = prod_ff[58:37];
               4'd13: begin
                  res_in[comp_idx] = calc_val;
                  step_in = 4'd0;
                  if (last_comp) state_in = ST_DONE;
                  cmp_in = (cmp_ff == 2'd2) ? 2'd0 : 2'(cmp_ff + 2'd1);
                  if (cmp_ff == 2'd2) vec_in = 2'(vec_ff + 2'd1);
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               rate_in      = new_rate_ff;
               wptr_in      = (wptr_ff == 3'd5) ? 3'd0 : 3'(wptr_ff + 3'd1);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         vec_ff       <= '0;
         cmp_ff       <= '0;
         wptr_ff      <= '0;
         wcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         init_ff[0]   <= ifbi_pkg::INIT_X_RESET;
         init_ff[1]   <= ifbi_pkg::INIT_Y_RESET;
         init_ff[2]   <= ifbi_pkg::INIT_Z_RESET;
         dt_ff        <= ifbi_pkg::DT_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         vec_ff       <= vec_in;
         cmp_ff       <= cmp_in;
         wptr_ff      <= wptr_in;
         wcnt_ff      <= wcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
         dt_ff        <= dt_in;
      end
      rate_ff     <= rate_in;
      new_rate_ff <= new_rate_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      prod_ff     <= prod_in;
      cr_ff       <= cr_in;
      hs_ff       <= hs_in;
      u_ff        <= u_in;
      sat_hi_ff   <= sat_hi_in;
      sat_lo_ff   <= sat_lo_in;
      q0_ff       <= q0_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) hist_mem[waddr] <= wr_data;
      rd_ff <= $signed(hist_mem[raddr]);
   end

endmodule

// File: bench/tb_top.sv
// Self-checking testbench of the BDF6 IMU frame integrator: directed and random gyro items.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 2000000;
   localparam int     STALL_LEN   = 400;
   localparam int     RATE_BITS   = ifbi_pkg::RATE_W;
   localparam int     NCOMP       = ifbi_pkg::NUM_COMP;
   localparam int     HDEPTH      = ifbi_pkg::HIST_DEPTH;

   typedef logic signed [ifbi_pkg::COMP_W-1:0] comp_type;
   typedef logic signed [RATE_BITS-1:0]        rate_type;
   typedef struct {
      comp_type c [NCOMP];
   } frame_type;

   logic clock;
   logic reset;

   ifbi_req_if req_bus ();
   ifbi_rsp_if rsp_bus ();
   ifbi_csr_if csr_bus ();

   imu_frame_bdf6_integrator_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // predictor state
   logic [ifbi_pkg::VEC_W-1:0] init_vec [3];
   logic [ifbi_pkg::DT_W-1:0]  dt_reg;
   longint           frame_hist [NCOMP][HDEPTH];
   longint           prev_rate [3];
   int               warm_taken;

   frame_type expected_frames [$];
   int     error_count;
   longint cycle_count;
   int     send_idle_pct;
   int     recv_idle_pct;
   int     stall_ticket;
   int     stall_served;
   int     stall_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint floor_div(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint clamp_comp(input longint v);
      if (v > 1048575) return 1048575;
      if (v < -1048576) return -1048576;
      return v;
   endfunction

   // advance the frame model by one gyro item and queue the expected frame
   task automatic predict_frame(input rate_type rx, ry, rz);
      longint res [NCOMP];
      longint cr [3];
      longint vx, vy, vz, c21, hs, num;
      longint den;
      frame_type f;
      den = longint'(147) << 28;
      if (warm_taken < ifbi_pkg::WARMUP_DEFAULT) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               res[i*3+k] = longint'($signed(init_vec[i][21*k +: ifbi_pkg::COMP_W]));
         warm_taken++;
      end else begin
         for (int i = 0; i < 3; i++) begin
            vx = frame_hist[i*3][0];
            vy = frame_hist[i*3+1][0];
            vz = frame_hist[i*3+2][0];
            cr[0] = vz * prev_rate[1] - vy * prev_rate[2];
            cr[1] = vx * prev_rate[2] - vz * prev_rate[0];
            cr[2] = vy * prev_rate[0] - vx * prev_rate[1];
            for (int k = 0; k < 3; k++) begin
               c21 = floor_div(cr[k] + 2048, 4096);
               hs = 360 * frame_hist[i*3+k][0] - 450 * frame_hist[i*3+k][1]
                  + 400 * frame_hist[i*3+k][2] - 225 * frame_hist[i*3+k][3]
                  + 72 * frame_hist[i*3+k][4] - 10 * frame_hist[i*3+k][5];
               num = 60 * c21 * longint'(dt_reg) + hs * (longint'(1) << 28);
               res[i*3+k] = clamp_comp(floor_div(num + den / 2, den));
            end
         end
      end
      for (int i = 0; i < NCOMP; i++) begin
         for (int k = HDEPTH - 1; k > 0; k--) frame_hist[i][k] = frame_hist[i][k-1];
         frame_hist[i][0] = res[i];
         f.c[i] = comp_type'(res[i]);
      end
      prev_rate[0] = longint'(rx);
      prev_rate[1] = longint'(ry);
      prev_rate[2] = longint'(rz);
      expected_frames.push_back(f);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic check_frame();
      frame_type want;
      comp_type got [NCOMP];
      got = '{rsp_bus.xvec_x, rsp_bus.xvec_y, rsp_bus.xvec_z,
              rsp_bus.yvec_x, rsp_bus.yvec_y, rsp_bus.yvec_z,
              rsp_bus.zvec_x, rsp_bus.zvec_y, rsp_bus.zvec_z};
      if (expected_frames.size() == 0) begin
         report_mismatch("unexpected frame item, xvec_x", got[0], 0);
      end else begin
         want = expected_frames.pop_front();
         for (int i = 0; i < NCOMP; i++)
            if (got[i] !== want.c[i])
               report_mismatch($sformatf("component %0d", i), got[i], want.c[i]);
      end
   endtask

   // result side: check, then pick ready for the next edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_frame();
      if (stall_ticket != stall_served) begin
         stall_served = stall_ticket;
         stall_left = STALL_LEN;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // valid is left high after an accept so back-to-back items need one assignment
   task automatic send_gyro(input rate_type rx, ry, rz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.rate_x <= rx;
      req_bus.rate_y <= ry;
      req_bus.rate_z <= rz;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predict_frame(rx, ry, rz);
   endtask

   task automatic idle_sender();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ifbi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ifbi_pkg::CSR_DATA_W-1:0] val);
      idle_sender();
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      case (idx)
         ifbi_pkg::REG_INIT_X:    init_vec[0] = val[ifbi_pkg::VEC_W-1:0];
         ifbi_pkg::REG_INIT_Y:    init_vec[1] = val[ifbi_pkg::VEC_W-1:0];
         ifbi_pkg::REG_INIT_Z:    init_vec[2] = val[ifbi_pkg::VEC_W-1:0];
         ifbi_pkg::REG_TIME_STEP: dt_reg = val[ifbi_pkg::DT_W-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ifbi_pkg::CSR_DATA_W-1:0] pack_vec(input comp_type a, b, c);
      return {1'b0, c, b, a};
   endfunction

   function automatic rate_type pick_rate();
      case ($urandom_range(3))
         0:       return RATE_BITS'($urandom);
         1:       return RATE_BITS'($signed($urandom_range(8191)) - 4096);
         default: return RATE_BITS'($signed($urandom_range(262143)) - 131072);
      endcase
   endfunction

   // warm-up frames, including a register change after the second warm-up item
   task automatic test_warmup_frames();
      write_reg(ifbi_pkg::REG_INIT_X,
                pack_vec(ifbi_pkg::COMP_MAX, ifbi_pkg::COMP_MIN, 21'sd0)
                | 64'h8000_0000_0000_0000);
      write_reg(ifbi_pkg::REG_INIT_Y, pack_vec(-21'sd1, 21'sd1, 21'sh0AAAAA));
      write_reg(ifbi_pkg::REG_INIT_Z, pack_vec(21'sh155555, 21'sd131072, -21'sd131072));
      send_gyro(24'sh7FFFFF, 24'sh800000, 24'sd0);
      send_gyro(-24'sd1, 24'sd1, 24'sh555555);
      write_reg(ifbi_pkg::REG_INIT_X, pack_vec(21'sd131072, 21'sd0, 21'sd0));
      write_reg(ifbi_pkg::REG_INIT_Y, pack_vec(21'sd0, 21'sd131072, 21'sd0));
      write_reg(ifbi_pkg::REG_INIT_Z, pack_vec(21'sd0, 21'sd0, 21'sd131072));
      send_gyro(24'sh2AAAAA, 24'sd65536, -24'sd65536);
      send_gyro(24'sd0, 24'sd0, 24'sd0);
      send_gyro(24'sd65536, 24'sd0, 24'sd0);
      send_gyro(24'sd0, 24'sd65536, -24'sd32768);
   endtask

   task automatic test_time_step_extremes();
      write_reg(ifbi_pkg::REG_TIME_STEP, 64'd0);
      send_gyro(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
      send_gyro(24'sd1000, -24'sd2000, 24'sd3000);
      write_reg(ifbi_pkg::REG_TIME_STEP, 64'hFFFF_FFFF_FF00_0001);
      send_gyro(24'sh800000, 24'sh7FFFFF, 24'sd0);
      send_gyro(24'sd5000, 24'sd5000, -24'sd5000);
      write_reg(ifbi_pkg::REG_TIME_STEP, 64'h0000_0000_00FF_FFFF);
      send_gyro(24'sh800000, 24'sh800000, 24'sh800000);
      send_gyro(24'sh7FFFFF, -24'sd1, 24'sd1);
      write_reg(ifbi_pkg::REG_TIME_STEP, {40'd0, ifbi_pkg::DT_RESET});
      send_gyro(24'sd6553, 24'sd0, -24'sd6553);
   endtask

   // writes to unused indexes must leave every register alone
   task automatic test_unknown_index();
      write_reg(8'd4, 64'd12345);
      write_reg(8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
      send_gyro(24'sd100, 24'sd200, 24'sd300);
      send_gyro(-24'sd100, -24'sd200, -24'sd300);
   endtask

   task automatic test_random_phases();
      int phase_send [4] = '{0, 52, 0, 36};
      int phase_recv [4] = '{0, 0, 52, 36};
      for (int p = 0; p < 4; p++) begin
         write_reg(ifbi_pkg::REG_TIME_STEP,
                   (p == 3) ? 64'($urandom) : 64'($urandom_range(400000, 1)));
         send_idle_pct = phase_send[p];
         recv_idle_pct = phase_recv[p];
         for (int n = 0; n < 100; n++) send_gyro(pick_rate(), pick_rate(), pick_rate());
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
   endtask

   task automatic test_backpressure();
      idle_sender();
      wait_drained();
      stall_ticket <= stall_ticket + 1;
      for (int n = 0; n < 12; n++) send_gyro(pick_rate(), pick_rate(), pick_rate());
      idle_sender();
      wait_drained();
      for (int n = 0; n < 12; n++) send_gyro(pick_rate(), pick_rate(), pick_rate());
      idle_sender();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rate_x = '0;
      req_bus.rate_y = '0;
      req_bus.rate_z = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      init_vec = '{ifbi_pkg::INIT_X_RESET, ifbi_pkg::INIT_Y_RESET, ifbi_pkg::INIT_Z_RESET};
      dt_reg = ifbi_pkg::DT_RESET;
      foreach (frame_hist[i, k]) frame_hist[i][k] = 0;
      prev_rate = '{0, 0, 0};
      warm_taken = 0;
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_ticket = 0;
      stall_served = 0;
      stall_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_warmup_frames();
      test_time_step_extremes();
      test_unknown_index();
      test_random_phases();
      test_backpressure();

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_frames.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/ifbi_pkg.sv
rtl/core/ifbi_channels.sv
rtl/core/imu_frame_bdf6_integrator_unit.sv
bench/tb_top.sv
